>>> src/emt_pkg.sv
package emt_pkg;

    localparam int OP_W     = 3;
    localparam int ID_W     = 6;
    localparam int CT_W     = 5;
    localparam int MASK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int MAX_ENTITIES_DEF    = 64;
    localparam int NUM_COMPONENT_TYPES = 32;
    localparam int RESULT_LIMIT        = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_HAS     = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   entity_id;
        logic [CT_W-1:0]   component_type;
        logic [MASK_W-1:0] query_mask;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     result_entity;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
        logic                last;
    } out_item_t;

    // decoded command as queued between front and back
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   entity_id;
        logic [MASK_W-1:0] comp_bit;
        logic [MASK_W-1:0] query_mask;
    } cmd_t;

endpackage

>>> src/emt_ram.sv
module emt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/emt_front.sv
module emt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  emt_pkg::in_item_t cmd,
    output logic              q_valid,
    output emt_pkg::cmd_t     q_cmd,
    input  logic              q_pop
);

    localparam int QD = emt_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int NW = $clog2(QD + 1);

    emt_pkg::cmd_t   q_reg [QD];
    emt_pkg::cmd_t   decoded;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            push;

    // component index past the configured set selects no bit
    always_comb
    begin
        decoded.opcode     = cmd.opcode;
        decoded.entity_id  = cmd.entity_id;
        decoded.query_mask = cmd.query_mask;
        if (int'(cmd.component_type) < emt_pkg::NUM_COMPONENT_TYPES)
        begin
            decoded.comp_bit = emt_pkg::MASK_W'(1) << cmd.component_type;
        end
        else
        begin
            decoded.comp_bit = '0;
        end
    end

    assign cmd_stall = (count_reg == NW'(QD));
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

>>> src/emt_back.sv
module emt_back #(
    parameter int MAX_ENTITIES = emt_pkg::MAX_ENTITIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  emt_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output emt_pkg::out_item_t rsp
);

    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam int IW = emt_pkg::ID_W;
    localparam int NW = emt_pkg::COUNT_W;
    localparam int MW = emt_pkg::MASK_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    emt_pkg::cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            top_reg, top_next;
    logic [CW-1:0]            hw_reg, hw_next;
    logic [CW-1:0]            live_reg, live_next;
    logic [MAX_ENTITIES-1:0]  alive_reg, alive_next;
    emt_pkg::out_item_t       out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     mask_we, mask_re;
    logic [AW-1:0]            mask_waddr, mask_raddr;
    logic [MW-1:0]            mask_wdata, mask_rdata;
    logic                     stack_we, stack_re;
    logic [AW-1:0]            stack_waddr, stack_raddr;
    logic [AW-1:0]            stack_wdata, stack_rdata;

    logic                     slot_free;
    logic                     emit;
    emt_pkg::out_item_t       res;
    logic                     allocated;
    logic [AW-1:0]            id_a;
    logic [AW-1:0]            nid;
    logic                     match;
    logic                     scan_end;
    logic                     final_match;
    logic [CW-1:0]            top_minus;
    logic [CW-1:0]            idx_plus;

    emt_ram #(.WIDTH(MW), .DEPTH(MAX_ENTITIES)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    emt_ram #(.WIDTH(AW), .DEPTH(MAX_ENTITIES)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign slot_free   = !out_valid_reg || !rsp_stall;
    assign allocated   = ({1'b0, cmd_reg.entity_id} < NW'(hw_reg));
    assign id_a        = cmd_reg.entity_id[AW-1:0];
    assign top_minus   = top_reg - CW'(1);
    assign idx_plus    = idx_reg + CW'(1);
    assign match       = ((mask_rdata & cmd_reg.query_mask) == cmd_reg.query_mask);
    assign scan_end    = (idx_plus == hw_reg);
    assign final_match = scan_end && (NW'(cnt_reg) == NW'(emt_pkg::RESULT_LIMIT - 1));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        hw_next        = hw_reg;
        live_next      = live_reg;
        alive_next     = alive_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        res            = '0;
        nid            = '0;
        mask_we        = 1'b0;
        mask_waddr     = id_a;
        mask_wdata     = '0;
        mask_re        = 1'b0;
        mask_raddr     = q_cmd.entity_id[AW-1:0];
        stack_we       = 1'b0;
        stack_waddr    = top_reg[AW-1:0];
        stack_wdata    = id_a;
        stack_re       = 1'b0;
        stack_raddr    = top_minus[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    mask_re  = 1'b1;
                    stack_re = 1'b1;
                    idx_next = '0;
                    cnt_next = '0;
                    if (q_cmd.opcode == emt_pkg::OP_QUERY)
                    begin
                        mask_raddr = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    res.last   = 1'b1;
                    res.status = emt_pkg::STATUS_OK;
                    state_next = ST_IDLE;
                    case (cmd_reg.opcode)
                        emt_pkg::OP_CREATE:
                        begin
                            if (top_reg != '0)
                            begin
                                nid      = stack_rdata;
                                top_next = top_minus;
                            end
                            else if (hw_reg < CW'(MAX_ENTITIES))
                            begin
                                // fresh identifier: its mask may be stale from before reset
                                nid        = hw_reg[AW-1:0];
                                hw_next    = hw_reg + CW'(1);
                                mask_we    = 1'b1;
                                mask_waddr = nid;
                                mask_wdata = '0;
                            end
                            else
                            begin
                                res.status = emt_pkg::STATUS_FULL;
                            end
                            if (res.status == emt_pkg::STATUS_OK)
                            begin
                                alive_next[nid]   = 1'b1;
                                live_next         = live_reg + CW'(1);
                                res.result_entity = IW'(nid);
                            end
                        end
                        emt_pkg::OP_DESTROY:
                        begin
                            if (allocated && alive_reg[id_a] &&
                                (top_reg < CW'(MAX_ENTITIES)))
                            begin
                                mask_we          = 1'b1;
                                mask_wdata       = '0;
                                alive_next[id_a] = 1'b0;
                                stack_we         = 1'b1;
                                top_next         = top_reg + CW'(1);
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                res.status = emt_pkg::STATUS_BAD_ID;
                            end
                        end
                        emt_pkg::OP_ADD, emt_pkg::OP_REMOVE:
                        begin
                            if (allocated)
                            begin
                                mask_we = 1'b1;
                                if (cmd_reg.opcode == emt_pkg::OP_ADD)
                                begin
                                    mask_wdata = mask_rdata | cmd_reg.comp_bit;
                                end
                                else
                                begin
                                    mask_wdata = mask_rdata & ~cmd_reg.comp_bit;
                                end
                            end
                            else
                            begin
                                res.status = emt_pkg::STATUS_BAD_ID;
                            end
                        end
                        emt_pkg::OP_HAS:
                        begin
                            if (allocated)
                            begin
                                res.found = |(mask_rdata & cmd_reg.comp_bit);
                            end
                            else
                            begin
                                res.status = emt_pkg::STATUS_BAD_ID;
                            end
                        end
                        default:
                        begin
                            res.status = emt_pkg::STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == hw_reg)
                begin
                    // end marker
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (match && !slot_free)
                begin
                    // hold the read data until the result register frees up
                    state_next = ST_SCAN;
                end
                else
                begin
                    if (match)
                    begin
                        emit              = 1'b1;
                        res.result_entity = IW'(idx_reg);
                        res.found         = 1'b1;
                        res.last          = final_match;
                        cnt_next          = cnt_reg + CW'(1);
                    end
                    if (match && final_match)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_plus;
                        mask_re    = 1'b1;
                        mask_raddr = idx_plus[AW-1:0];
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.live_count = NW'(live_next);

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            top_reg       <= '0;
            hw_reg        <= '0;
            live_reg      <= '0;
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            hw_reg        <= hw_next;
            live_reg      <= live_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // every allocated identifier is either live or on the free stack
    a_id_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (NW'(top_reg) + NW'(live_reg)) == NW'(hw_reg))
        else $error("free stack and live count do not add up to high-water mark");

    a_alive_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(alive_reg) == int'(live_reg))
        else $error("alive bits disagree with live count");

    a_scan_is_query: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cmd_reg.opcode == emt_pkg::OP_QUERY)
        else $error("scan running for a non-query command");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg <= hw_reg)
        else $error("scan index ran past high-water mark");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE && q_valid)
        else $error("queue popped while a command is in progress");

endmodule

>>> src/entity_mask_table_engine.sv
// entity table with per-entity component bitmasks and a lifo free list
// command channel (cmd_valid / cmd_stall / cmd): one beat per operation;
// beats land in a two-entry queue, so cmd_stall rises only when it is full
// response channel (rsp_valid / rsp_stall / rsp): results in order, the
// final beat of each command has last set
// create, destroy, add, remove, has: one response beat; the idle executor pops
// a command and reads the mask ram, then loads the result register once it is
// free, doing the mask ram read-modify-write; it pops no new command till then
// query: one mask ram read per identifier below the high-water mark; each match
// is emitted, waiting while the result register is held; an end marker follows
// unless the last identifier gives the RESULT_LIMIT-th match, which has last set
// rsp_stall holds the result register; a beat to load then waits, and the
// queue keeps taking commands until both entries are taken
// reset clears the counters, alive bits and both channels at once; no
// clearing pass: a fresh identifier has its mask zeroed when it is created
module entity_mask_table_engine #(
    parameter int MAX_ENTITIES = emt_pkg::MAX_ENTITIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  emt_pkg::in_item_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output emt_pkg::out_item_t rsp
);

    logic          q_valid;
    logic          q_pop;
    emt_pkg::cmd_t q_cmd;

    emt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    emt_back #(.MAX_ENTITIES(MAX_ENTITIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> verif/mask_table_checker.sv
`timescale 1ns / 100ps

module mask_table_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  emt_pkg::in_item_t  cmd,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  emt_pkg::out_item_t rsp,
    output int                 mismatch_count,
    output int                 responses_owed
);

    // shadow copy of the entity table
    logic [emt_pkg::MASK_W-1:0] comp_masks [emt_pkg::MAX_ENTITIES_DEF];
    logic                       alive      [emt_pkg::MAX_ENTITIES_DEF];
    logic [emt_pkg::ID_W-1:0]   free_ids   [emt_pkg::MAX_ENTITIES_DEF];
    int                         free_depth;
    int                         high_water;
    int                         live_total;

    emt_pkg::out_item_t due_responses[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void owe_response(input logic [emt_pkg::ID_W-1:0] ent,
                                         input logic fnd,
                                         input logic [emt_pkg::STATUS_W-1:0] st,
                                         input logic lst);
        emt_pkg::out_item_t r;
        r.result_entity = ent;
        r.found         = fnd;
        r.status        = st;
        r.live_count    = emt_pkg::COUNT_W'(live_total);
        r.last          = lst;
        due_responses   = {due_responses, r};
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < emt_pkg::MAX_ENTITIES_DEF; i++)
        begin
            comp_masks[i] = '0;
            alive[i]      = 1'b0;
            free_ids[i]   = '0;
        end
        free_depth = 0;
        high_water = 0;
        live_total = 0;
        due_responses.delete();
    endfunction

    // works out the responses to one command and updates the shadow table
    function automatic void apply_table_op(input emt_pkg::in_item_t c);
        logic                       known;
        logic [emt_pkg::MASK_W-1:0] comp_sel;
        logic [emt_pkg::ID_W-1:0]   nid;
        int                         hits;
        known    = c.entity_id < high_water;
        comp_sel = (c.component_type < emt_pkg::NUM_COMPONENT_TYPES)
                   ? (emt_pkg::MASK_W'(1) << c.component_type) : '0;
        case (c.opcode)
            emt_pkg::OP_CREATE:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    nid = free_ids[free_depth];
                end
                else if (high_water < emt_pkg::MAX_ENTITIES_DEF)
                begin
                    nid = emt_pkg::ID_W'(high_water);
                    high_water++;
                end
                else
                begin
                    owe_response('0, 1'b0, emt_pkg::STATUS_FULL, 1'b1);
                    return;
                end
                alive[nid] = 1'b1;
                live_total++;
                owe_response(nid, 1'b0, emt_pkg::STATUS_OK, 1'b1);
            end
            emt_pkg::OP_DESTROY:
            begin
                if (!known || !alive[c.entity_id] ||
                    free_depth >= emt_pkg::MAX_ENTITIES_DEF)
                begin
                    owe_response('0, 1'b0, emt_pkg::STATUS_BAD_ID, 1'b1);
                    return;
                end
                comp_masks[c.entity_id] = '0;
                alive[c.entity_id]      = 1'b0;
                free_ids[free_depth]    = c.entity_id;
                free_depth++;
                if (live_total > 0)
                    live_total--;
                owe_response('0, 1'b0, emt_pkg::STATUS_OK, 1'b1);
            end
            emt_pkg::OP_ADD, emt_pkg::OP_REMOVE, emt_pkg::OP_HAS:
            begin
                // dead but once allocated identifiers are still usable here
                if (!known)
                    owe_response('0, 1'b0, emt_pkg::STATUS_BAD_ID, 1'b1);
                else if (c.opcode == emt_pkg::OP_ADD)
                begin
                    comp_masks[c.entity_id] |= comp_sel;
                    owe_response('0, 1'b0, emt_pkg::STATUS_OK, 1'b1);
                end
                else if (c.opcode == emt_pkg::OP_REMOVE)
                begin
                    comp_masks[c.entity_id] &= ~comp_sel;
                    owe_response('0, 1'b0, emt_pkg::STATUS_OK, 1'b1);
                end
                else
                    owe_response('0, |(comp_masks[c.entity_id] & comp_sel),
                                 emt_pkg::STATUS_OK, 1'b1);
            end
            emt_pkg::OP_QUERY:
            begin
                hits = 0;
                for (int i = 0; i < high_water; i++)
                begin
                    if ((comp_masks[i] & c.query_mask) == c.query_mask)
                    begin
                        owe_response(emt_pkg::ID_W'(i), 1'b1, emt_pkg::STATUS_OK, 1'b0);
                        hits++;
                    end
                end
                // a full house of hits ends on the last match, no marker
                if (hits >= emt_pkg::RESULT_LIMIT)
                    due_responses[due_responses.size() - 1].last = 1'b1;
                else
                    owe_response('0, 1'b0, emt_pkg::STATUS_OK, 1'b1);
            end
            default:
                owe_response('0, 1'b0, emt_pkg::STATUS_OK, 1'b1);
        endcase
    endfunction

    task automatic check_beat(input emt_pkg::out_item_t got);
        emt_pkg::out_item_t want;
        if (due_responses.size() == 0)
        begin
            report_mismatch("response beat with none pending", 32'(got), '0);
            return;
        end
        want = due_responses.pop_front();
        if (got.result_entity !== want.result_entity)
            report_mismatch("result_entity", 32'(got.result_entity), 32'(want.result_entity));
        if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.live_count !== want.live_count)
            report_mismatch("live_count", 32'(got.live_count), 32'(want.live_count));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            mismatch_count = 0;
            responses_owed = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                apply_table_op(cmd);
            if (rsp_valid && !rsp_stall)
                check_beat(rsp);
            responses_owed = due_responses.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [emt_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [emt_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int ITEM_TARGET = 220;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    emt_pkg::in_item_t  cmd;
    logic               rsp_valid;
    logic               rsp_stall;
    emt_pkg::out_item_t rsp;

    int mismatch_count;
    int responses_owed;
    int items_sent = 0;
    int id_reach   = 0;
    int burst_left = 0;
    bit hold_done  = 1'b0;

    always #5 clk = ~clk;

    entity_mask_table_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    mask_table_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .responses_owed (responses_owed)
    );

    function automatic emt_pkg::in_item_t make_item(
        input logic [emt_pkg::OP_W-1:0]   op,
        input logic [emt_pkg::ID_W-1:0]   ent,
        input logic [emt_pkg::CT_W-1:0]   comp,
        input logic [emt_pkg::MASK_W-1:0] need);
        emt_pkg::in_item_t it;
        it.opcode         = op;
        it.entity_id      = ent;
        it.component_type = comp;
        it.query_mask     = need;
        return it;
    endfunction

    function automatic logic [emt_pkg::ID_W-1:0] rand_id();
        return emt_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [emt_pkg::CT_W-1:0] rand_comp();
        return emt_pkg::CT_W'($urandom);
    endfunction

    // mostly identifiers that have likely been handed out already
    function automatic logic [emt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 4) == 0)
            return emt_pkg::ID_W'($urandom_range(0, emt_pkg::MAX_ENTITIES_DEF - 1));
        return emt_pkg::ID_W'($urandom_range(0, id_reach));
    endfunction

    function automatic logic [emt_pkg::MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return emt_pkg::MASK_W'(1) << $urandom_range(0, emt_pkg::MASK_W - 1);
            2:       return (emt_pkg::MASK_W'(1) << $urandom_range(0, 7))
                            | (emt_pkg::MASK_W'(1) << $urandom_range(0, 7));
            3, 4:    return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic emt_pkg::in_item_t rand_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            return make_item(emt_pkg::OP_CREATE, rand_id(), rand_comp(), $urandom);
        if (pick < 34)
            return make_item(emt_pkg::OP_DESTROY, pick_id(), rand_comp(), $urandom);
        if (pick < 56)
            return make_item(emt_pkg::OP_ADD, pick_id(), rand_comp(), $urandom);
        if (pick < 66)
            return make_item(emt_pkg::OP_REMOVE, pick_id(), rand_comp(), $urandom);
        if (pick < 80)
            return make_item(emt_pkg::OP_HAS, pick_id(), rand_comp(), $urandom);
        if (pick < 92)
            return make_item(emt_pkg::OP_QUERY, rand_id(), rand_comp(), pick_mask());
        return make_item($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                         rand_id(), rand_comp(), $urandom);
    endfunction

    // bursts of random length, some of them run back to back with no gap
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk) cmd_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer_beat(input emt_pkg::in_item_t item);
        pace_sender();
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
        if (item.opcode == emt_pkg::OP_CREATE && id_reach < emt_pkg::MAX_ENTITIES_DEF - 1)
            id_reach++;
    endtask

    // create one, tag a picked id with 1-4 components, look it up, take one away, maybe destroy
    task automatic run_entity_story();
        logic [emt_pkg::ID_W-1:0]   ent;
        logic [emt_pkg::CT_W-1:0]   comp;
        logic [emt_pkg::MASK_W-1:0] held;
        int                         adds;
        offer_beat(make_item(emt_pkg::OP_CREATE, rand_id(), rand_comp(), $urandom));
        ent  = pick_id();
        held = '0;
        comp = '0;
        adds = $urandom_range(1, 4);
        repeat (adds)
        begin
            comp = ($urandom_range(0, 3) == 0) ? rand_comp()
                                               : emt_pkg::CT_W'($urandom_range(0, 7));
            held |= emt_pkg::MASK_W'(1) << comp;
            offer_beat(make_item(emt_pkg::OP_ADD, ent, comp, $urandom));
        end
        offer_beat(make_item(emt_pkg::OP_HAS, ent, comp, $urandom));
        offer_beat(make_item(emt_pkg::OP_QUERY, ent, comp, held));
        offer_beat(make_item(emt_pkg::OP_REMOVE, ent, comp, $urandom));
        offer_beat(make_item(emt_pkg::OP_QUERY, ent, comp, held));
        if ($urandom_range(0, 1))
            offer_beat(make_item(emt_pkg::OP_DESTROY, ent, comp, $urandom));
    endtask

    task automatic run_mix(input int until_count);
        while (items_sent < until_count)
        begin
            if ($urandom_range(0, 5) == 0)
                run_entity_story();
            else
                offer_beat(rand_item());
        end
    endtask

    task automatic run_directed();
        offer_beat(make_item(emt_pkg::OP_HAS, 6'd0, 5'd0, '0));            // empty table
        offer_beat(make_item(emt_pkg::OP_DESTROY, 6'd0, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_ADD, 6'd63, 5'd31, '1));
        offer_beat(make_item(emt_pkg::OP_QUERY, 6'd0, 5'd0, '0));          // marker only
        offer_beat(make_item(emt_pkg::OP_CREATE, 6'd0, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_CREATE, 6'd63, 5'd31, '1));
        offer_beat(make_item(emt_pkg::OP_ADD, 6'd0, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_ADD, 6'd0, 5'd31, '0));
        offer_beat(make_item(emt_pkg::OP_ADD, 6'd1, 5'd31, '0));
        offer_beat(make_item(emt_pkg::OP_HAS, 6'd0, 5'd31, '0));
        offer_beat(make_item(emt_pkg::OP_HAS, 6'd1, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_QUERY, 6'd0, 5'd0, 32'h8000_0000));
        offer_beat(make_item(emt_pkg::OP_QUERY, 6'd0, 5'd0, 32'hFFFF_FFFF));
        offer_beat(make_item(emt_pkg::OP_QUERY, 6'd0, 5'd0, 32'h8000_0001));
        offer_beat(make_item(emt_pkg::OP_REMOVE, 6'd0, 5'd31, '0));
        offer_beat(make_item(emt_pkg::OP_DESTROY, 6'd1, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_DESTROY, 6'd1, 5'd0, '0));        // already dead
        offer_beat(make_item(emt_pkg::OP_ADD, 6'd1, 5'd5, '0));            // dead, still allocated
        offer_beat(make_item(emt_pkg::OP_CREATE, 6'd0, 5'd0, '0));         // reuses freed id
        offer_beat(make_item(OP_SPARE_A, 6'd63, 5'd31, '1));
        offer_beat(make_item(OP_SPARE_B, 6'd0, 5'd0, '0));
        offer_beat(make_item(emt_pkg::OP_DESTROY, 6'd63, 5'd31, '0));      // out of range
        offer_beat(make_item(emt_pkg::OP_QUERY, 6'd63, 5'd31, '0));
    endtask

    initial
    begin
        cmd_valid = 1'b0;
        cmd       = '0;
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        run_directed();
        run_mix(85);
        // fill the table past its capacity, then match everything
        repeat (emt_pkg::MAX_ENTITIES_DEF + 2)
            offer_beat(make_item(emt_pkg::OP_CREATE, rand_id(), rand_comp(), $urandom));
        offer_beat(make_item(emt_pkg::OP_QUERY, rand_id(), rand_comp(), '0));
        run_mix(ITEM_TARGET);

        @(negedge clk) cmd_valid <= 1'b0;
        while (responses_owed != 0)
            @(negedge clk);
        // room for a full scan in case the block emits beats nobody owes
        repeat (emt_pkg::MAX_ENTITIES_DEF + 16) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // receiver stalls on its own pattern, with one long hold-off to back up the input
    initial
    begin
        int mode;
        int span;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && items_sent >= 40)
            begin
                hold_done = 1'b1;
                @(negedge clk) rsp_stall <= 1'b1;
                repeat (90) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ~rsp_stall;
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/emt_pkg.sv
src/emt_ram.sv
src/emt_front.sv
src/emt_back.sv
src/entity_mask_table_engine.sv
verif/mask_table_checker.sv
verif/testbench.sv
